// File: src/pmu_pkg.sv
// Shared types and constants for the pheromone matrix update core.
// No dependencies; imported by the interfaces, the divider and the top level.
package pmu_pkg;

	// Matrix geometry
	localparam int MAX_CITIES = 64;
	localparam int IDX_W      = $clog2(MAX_CITIES);
	localparam int ADDR_W     = $clog2(MAX_CITIES * MAX_CITIES);
	localparam int CMP_W      = 11;  // wide enough to compare a city against up to 1024

	// Transaction field widths
	localparam int OP_W   = 2;
	localparam int CITY_W = 6;
	localparam int AMT_W  = 32;
	localparam int LVL_W  = 48;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = LVL_W;
	localparam logic [CFG_IDX_W-1:0] CFG_EVAP_RATE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 1'd1;
	localparam int RATE_W          = 16;
	localparam int RATE_RESET      = 655;
	localparam int MIN_LEVEL_RESET = 110;

	// Opcodes
	localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
	localparam logic [OP_W-1:0] OP_EVAP    = 2'd1;
	localparam logic [OP_W-1:0] OP_DEPOSIT = 2'd2;
	localparam logic [OP_W-1:0] OP_READ    = 2'd3;

	// Arithmetic
	localparam logic [LVL_W-1:0] LVL_MAX = {LVL_W{1'b1}};
	localparam int RECIP_W   = 41;  // 2^40 / n needs 41 bits for n == 1
	localparam int DIV_CNT_W = $clog2(RECIP_W + 1);
	localparam int FAC_W     = RATE_W + 1;
	localparam int FAC_ONE   = 65536;
	localparam int MUL_A_W   = LVL_W / 2;
	localparam int MUL_P_W   = MUL_A_W + FAC_W;
	localparam int EVSUM_W   = MUL_P_W + MUL_A_W;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: src/pmu_cmd_if.sv
// Command channel of the pheromone matrix update core: valid/ready plus payload.
// Depends on pmu_pkg for field widths.
interface pmu_cmd_if import pmu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [CITY_W-1:0] row_city;
	logic [CITY_W-1:0] col_city;
	logic [AMT_W-1:0]  amount;

	modport source (output valid, output opcode, output row_city, output col_city,
		output amount, input ready);
	modport sink (input valid, input opcode, input row_city, input col_city,
		input amount, output ready);
endinterface

// File: src/pmu_rsp_if.sv
// Response channel of the pheromone matrix update core: valid/ready plus payload.
// Depends on pmu_pkg for field widths.
interface pmu_rsp_if import pmu_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LVL_W-1:0] level;
	logic             saturated;

	modport source (output valid, output level, output saturated, input ready);
	modport sink (input valid, input level, input saturated, output ready);
endinterface

// File: src/pmu_recip_div.sv
// Bit-serial restoring divider computing 2^40 / divisor, one quotient bit per cycle.
// Depends on pmu_pkg; used by pheromone_matrix_update_core.
module pmu_recip_div import pmu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [AMT_W-1:0]   divisor,
	output logic [RECIP_W-1:0] quotient,
	output div_stat_t          stat
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [AMT_W-1:0]     rem_q;
	logic [AMT_W-1:0]     dvs_q;
	logic [RECIP_W-1:0]   quo_q;

	logic                 bit_in;
	logic [AMT_W:0]       trial;
	logic [AMT_W+1:0]     diff;
	logic                 ge;

	// Dividend is a single one at the top bit, so only the first step shifts in a one
	assign bit_in = (cnt_q == DIV_CNT_W'(RECIP_W));
	assign trial  = {rem_q, bit_in};
	assign diff   = {1'b0, trial} - {2'b00, dvs_q};
	assign ge     = ~diff[AMT_W+1];

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(RECIP_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[AMT_W-1:0] : trial[AMT_W-1:0];
			quo_q <= {quo_q[RECIP_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: src/pheromone_matrix_update_core.sv
// Pheromone matrix update core: sequencer, 4096 x 48 level store, shared multiplier.
// Depends on pmu_pkg, pmu_cmd_if, pmu_rsp_if and pmu_recip_div.
//
// Usage: the cmd channel carries one transaction per command (opcode, row_city,
// col_city, amount); the rsp channel returns exactly one transaction per command
// with the resulting level and the saturated flag. Both use valid/ready and move
// a transaction on a clock edge where both are high. Configuration registers
// (evaporation_rate, min_level) are written through cfg_wr_en/cfg_index/cfg_data
// while no command is in flight.
// The core handles one command at a time and raises cmd.ready only when idle.
// Path from the accepting edge to rsp.valid: read passes S_RD, S_RDOUT and S_FIN;
// init and deposit first wait on the bit-serial reciprocal divider (41 quotient
// steps plus a registered done flag); zero distance init and zero cost deposit
// skip the divider and diagonal init also skips S_LAUNCH; evaporate walks the full
// 64 x 64 matrix, each entry through S_EV_RD, S_EV_ML, S_EV_MH, S_EV_SUM and S_EV_WR
// on the shared 24x17 multiplier. cmd.ready returns on the edge that loads the result.
// A finished response sits in an output register; if rsp.ready is low the core
// holds it and can still accept the next command, but stalls before delivering
// that one's result until the register is free.
// Reset (arst_n low) clears the sequencer and restores the register defaults;
// matrix entries are undefined until written by init.
module pheromone_matrix_update_core import pmu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	pmu_cmd_if.sink               cmd,
	pmu_rsp_if.source             rsp,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Sequencer state codes
	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
	localparam logic [ST_W-1:0] S_LAUNCH = 4'd1;
	localparam logic [ST_W-1:0] S_DIV    = 4'd2;
	localparam logic [ST_W-1:0] S_RD     = 4'd3;
	localparam logic [ST_W-1:0] S_DEP    = 4'd4;
	localparam logic [ST_W-1:0] S_RDOUT  = 4'd5;
	localparam logic [ST_W-1:0] S_WR1    = 4'd6;
	localparam logic [ST_W-1:0] S_WR2    = 4'd7;
	localparam logic [ST_W-1:0] S_EV_RD  = 4'd8;
	localparam logic [ST_W-1:0] S_EV_ML  = 4'd9;
	localparam logic [ST_W-1:0] S_EV_MH  = 4'd10;
	localparam logic [ST_W-1:0] S_EV_SUM = 4'd11;
	localparam logic [ST_W-1:0] S_EV_WR  = 4'd12;
	localparam logic [ST_W-1:0] S_FIN    = 4'd13;

	logic [ST_W-1:0]    state_q;
	logic [RATE_W-1:0]  evap_rate_q;
	logic [LVL_W-1:0]   min_level_q;

	// Command context
	logic [OP_W-1:0]    op_q;
	logic [AMT_W-1:0]   amt_q;
	logic [ADDR_W-1:0]  rc_addr_q;
	logic [ADDR_W-1:0]  cr_addr_q;
	logic [LVL_W-1:0]   level_q;
	logic               sat_q;
	logic [LVL_W-1:0]   recip_q;

	// Evaporation walk
	logic [IDX_W-1:0]   ev_row_q;
	logic [IDX_W-1:0]   ev_col_q;
	logic [MUL_P_W-1:0] prod_lo_q;
	logic [MUL_P_W-1:0] prod_hi_q;
	logic [LVL_W-1:0]   evsum_q;

	// Level store
	logic [LVL_W-1:0]   pher_mem [MAX_CITIES*MAX_CITIES];
	logic [LVL_W-1:0]   rdata_q;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [LVL_W-1:0]   wr_data;

	// Output register
	logic               out_valid_q;
	logic [LVL_W-1:0]   out_level_q;
	logic               out_sat_q;
	logic               out_load;

	// Misc combinational
	logic               cmd_acc;
	logic               in_range;
	logic               cmd_diag;
	logic [ADDR_W-1:0]  cmd_rc;
	logic [ADDR_W-1:0]  cmd_cr;
	logic [ADDR_W-1:0]  ev_addr;
	logic               ev_diag;
	logic               ev_last;
	logic [FAC_W-1:0]   factor;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_P_W-1:0] mul_p;
	logic [EVSUM_W-1:0] evsum_full;
	logic [LVL_W-1:0]   ev_val;
	logic [LVL_W:0]     dep_sum;
	logic               div_start;
	logic [RECIP_W-1:0] div_quot;
	div_stat_t          div_stat;

	// Handshake and address decode
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign in_range  = (CMP_W'(cmd.row_city) < CMP_W'(MAX_CITIES))
		&& (CMP_W'(cmd.col_city) < CMP_W'(MAX_CITIES));
	assign cmd_diag  = (cmd.row_city == cmd.col_city);
	assign cmd_rc    = ADDR_W'(cmd.row_city) * ADDR_W'(MAX_CITIES) + ADDR_W'(cmd.col_city);
	assign cmd_cr    = ADDR_W'(cmd.col_city) * ADDR_W'(MAX_CITIES) + ADDR_W'(cmd.row_city);

	assign ev_addr = ADDR_W'(ev_row_q) * ADDR_W'(MAX_CITIES) + ADDR_W'(ev_col_q);
	assign ev_diag = (ev_row_q == ev_col_q);
	assign ev_last = (ev_row_q == IDX_W'(MAX_CITIES - 1)) && (ev_col_q == IDX_W'(MAX_CITIES - 1));

	// Shared multiplier: low half then high half of the stored level
	assign factor     = FAC_W'(FAC_ONE) - FAC_W'(evap_rate_q);
	assign mul_a      = (state_q == S_EV_MH) ? rdata_q[LVL_W-1:MUL_A_W] : rdata_q[MUL_A_W-1:0];
	assign mul_p      = MUL_P_W'(mul_a) * MUL_P_W'(factor);
	assign evsum_full = {prod_hi_q, {MUL_A_W{1'b0}}} + EVSUM_W'(prod_lo_q);
	assign ev_val     = (!ev_diag && (evsum_q < min_level_q)) ? min_level_q : evsum_q;

	// Deposit sum with carry-out for saturation
	assign dep_sum = {1'b0, rdata_q} + {1'b0, recip_q};

	assign div_start = (state_q == S_LAUNCH) && (amt_q != '0);

	pmu_recip_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (amt_q),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	// Store port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rc_addr_q;
		wr_en   = 1'b0;
		wr_addr = rc_addr_q;
		wr_data = level_q;
		unique case (state_q)
			S_RD: begin
				rd_en = 1'b1;
			end
			S_EV_RD: begin
				rd_en   = 1'b1;
				rd_addr = ev_addr;
			end
			S_WR1: begin
				wr_en = 1'b1;
			end
			S_WR2: begin
				wr_en   = 1'b1;
				wr_addr = cr_addr_q;
			end
			S_EV_WR: begin
				wr_en   = 1'b1;
				wr_addr = ev_addr;
				wr_data = ev_val;
			end
			default: begin
			end
		endcase
	end

	// Level store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pher_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= pher_mem[rd_addr];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evap_rate_q <= RATE_W'(RATE_RESET);
			min_level_q <= LVL_W'(MIN_LEVEL_RESET);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_EVAP_RATE: evap_rate_q <= cfg_data[RATE_W-1:0];
				CFG_MIN_LEVEL: min_level_q <= cfg_data[LVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						if (cmd.opcode == OP_EVAP) begin
							state_q <= S_EV_RD;
						end else if (!in_range) begin
							state_q <= S_FIN;
						end else if (cmd.opcode == OP_READ) begin
							state_q <= S_RD;
						end else if (cmd.opcode == OP_INIT && cmd_diag) begin
							state_q <= S_WR1;
						end else begin
							state_q <= S_LAUNCH;
						end
					end
				end
				S_LAUNCH: begin
					if (amt_q != '0) begin
						state_q <= S_DIV;
					end else if (op_q == OP_INIT) begin
						state_q <= S_WR1;
					end else begin
						state_q <= S_RD;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= (op_q == OP_INIT) ? S_WR1 : S_RD;
					end
				end
				S_RD:     state_q <= (op_q == OP_READ) ? S_RDOUT : S_DEP;
				S_RDOUT:  state_q <= S_FIN;
				S_DEP:    state_q <= S_WR1;
				S_WR1:    state_q <= S_WR2;
				S_WR2:    state_q <= S_FIN;
				S_EV_RD:  state_q <= S_EV_ML;
				S_EV_ML:  state_q <= S_EV_MH;
				S_EV_MH:  state_q <= S_EV_SUM;
				S_EV_SUM: state_q <= S_EV_WR;
				S_EV_WR:  state_q <= ev_last ? S_FIN : S_EV_RD;
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command context and arithmetic registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q      <= cmd.opcode;
				amt_q     <= cmd.amount;
				rc_addr_q <= cmd_rc;
				cr_addr_q <= cmd_cr;
				level_q   <= '0;
				sat_q     <= 1'b0;
				ev_row_q  <= '0;
				ev_col_q  <= '0;
			end
			S_LAUNCH: begin
				// Zero divisor saturates the reciprocal
				recip_q <= LVL_MAX;
				level_q <= LVL_MAX;
				sat_q   <= (amt_q == '0);
			end
			S_DIV: begin
				recip_q <= LVL_W'(div_quot);
				level_q <= LVL_W'(div_quot);
			end
			S_RDOUT: begin
				level_q <= rdata_q;
			end
			S_DEP: begin
				if (dep_sum[LVL_W]) begin
					level_q <= LVL_MAX;
					sat_q   <= 1'b1;
				end else begin
					level_q <= dep_sum[LVL_W-1:0];
				end
			end
			S_EV_ML: begin
				prod_lo_q <= mul_p;
			end
			S_EV_MH: begin
				prod_hi_q <= mul_p;
			end
			S_EV_SUM: begin
				evsum_q <= evsum_full[LVL_W+RATE_W-1:RATE_W];
			end
			S_EV_WR: begin
				if (ev_col_q == IDX_W'(MAX_CITIES - 1)) begin
					ev_col_q <= '0;
					ev_row_q <= ev_row_q + IDX_W'(1);
				end else begin
					ev_col_q <= ev_col_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Response register
	assign out_load = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_level_q <= level_q;
			out_sat_q   <= sat_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.level     = out_level_q;
	assign rsp.saturated = out_sat_q;

endmodule
